@@ rtl/amb_pkg.sv @@
// Shared constants, register indexes and item types of the meter ballistics block.
package amb_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int CH_W = 3;
	localparam int LVL_W = 16;
	localparam int TS_W = 32;
	localparam int EL_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAG_TIME = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IN_PEAK_HOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 3'd4;

	localparam logic [15:0] RST_PEAK_DECAY = 16'd3011;
	localparam logic [23:0] RST_MAG_TIME = 24'd300000;
	localparam logic [31:0] RST_PEAK_HOLD = 32'd20000000;
	localparam logic [31:0] RST_IN_PEAK_HOLD = 32'd1000000;
	localparam logic signed [15:0] RST_MIN_LEVEL = -16'sd15360;

	localparam logic signed [LVL_W-1:0] MINUS_INF = 16'sh8000;

	localparam int MD_A_W = 23;
	localparam int MD_B_W = EL_W;
	localparam int MD_D_W = 31;
	localparam int MD_P_W = MD_A_W + MD_B_W;

	localparam logic [MD_D_W-1:0] DECAY_DIV = 31'd1000000;
	localparam logic [6:0] MAG_GAIN = 7'd99;
	localparam logic [6:0] MAG_DEN_GAIN = 7'd100;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic [TS_W-1:0] timestamp;
		logic [EL_W-1:0] elapsed;
		logic signed [LVL_W-1:0] peak_level;
		logic signed [LVL_W-1:0] input_peak_level;
		logic signed [LVL_W-1:0] magnitude_level;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0] out_channel;
		logic signed [LVL_W-1:0] shown_peak;
		logic signed [LVL_W-1:0] shown_input_peak;
		logic signed [LVL_W-1:0] shown_peak_hold;
		logic signed [LVL_W-1:0] shown_input_peak_hold;
		logic signed [LVL_W-1:0] shown_magnitude;
	} out_item_t;

endpackage

@@ rtl/amb_stream_if.sv @@
// Valid/ready item channel with a typed payload.
interface amb_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/amb_muldiv.sv @@
// Bit-serial multiply then restoring divide: q = a * b / d.
module amb_muldiv #(
	parameter int A_W = amb_pkg::MD_A_W,
	parameter int B_W = amb_pkg::MD_B_W,
	parameter int D_W = amb_pkg::MD_D_W
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [A_W-1:0] a,
	input  logic [B_W-1:0] b,
	input  logic [D_W-1:0] d,
	output logic done,
	output logic [A_W+B_W-1:0] q
);
	localparam int P_W = A_W + B_W;
	localparam int CNT_W = $clog2(P_W);

	typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

	md_state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [P_W-1:0] acc_q;
	logic [A_W-1:0] a_q;
	logic [B_W-1:0] b_q;
	logic [D_W-1:0] d_q;
	logic [D_W-1:0] rem_q;
	logic done_q;
	logic [D_W:0] rem_sh;
	logic rem_ge;

	assign rem_sh = {rem_q, acc_q[P_W-1]};
	assign rem_ge = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MD_IDLE: begin
					if (start) begin
						state_q <= MD_MUL;
						cnt_q <= CNT_W'(B_W - 1);
					end
				end
				MD_MUL: begin
					if (cnt_q == '0) begin
						state_q <= MD_DIV;
						cnt_q <= CNT_W'(P_W - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				MD_DIV: begin
					if (cnt_q == '0) begin
						state_q <= MD_IDLE;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			MD_IDLE: begin
				if (start) begin
					a_q <= a;
					b_q <= b;
					d_q <= d;
					acc_q <= '0;
					rem_q <= '0;
				end
			end
			MD_MUL: begin
				acc_q <= (acc_q << 1) + (b_q[B_W-1] ? P_W'(a_q) : '0);
				b_q <= b_q << 1;
			end
			MD_DIV: begin
				rem_q <= rem_ge ? D_W'(rem_sh - {1'b0, d_q}) : rem_sh[D_W-1:0];
				acc_q <= {acc_q[P_W-2:0], rem_ge};
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign done = done_q;
	assign q = acc_q;
endmodule

@@ rtl/audio_meter_ballistics.sv @@
// Per-channel meter ballistics: peak decay, peak hold and integrated magnitude.
// A new item is taken only in the idle state, once the previous result has been loaded.
// Each item runs through two bit-serial multiply-divide units side by side:
// 24 multiply steps (one elapsed bit each) then 47 restoring division steps.
// A finished result waits in the output register while the next item is taken.
// Reset clears the configuration to defaults, the valid bits and the hold stores.
module audio_meter_ballistics #(
	parameter int CHANNELS = amb_pkg::CHANNELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [amb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [amb_pkg::CFG_DATA_W-1:0] cfg_wdata,
	amb_stream_if.sink update,
	amb_stream_if.source result
);
	import amb_pkg::*;

	localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WAIT, ST_FIN} state_t;

	state_t state_q;
	in_item_t item_q;
	out_item_t res_q;
	logic res_v_q;

	logic [15:0] decay_rate_q;
	logic [23:0] mag_time_q;
	logic [31:0] peak_hold_q;
	logic [31:0] in_peak_hold_q;
	logic signed [15:0] min_level_q;

	logic vld_q [CHANNELS];
	logic signed [LVL_W-1:0] disp_pk_q [CHANNELS];
	logic signed [LVL_W-1:0] disp_ipk_q [CHANNELS];
	logic signed [LVL_W-1:0] disp_mag_q [CHANNELS];
	logic signed [LVL_W-1:0] hold_pk_q [CHANNELS];
	logic signed [LVL_W-1:0] hold_ipk_q [CHANNELS];
	logic [TS_W-1:0] hold_pk_ts_q [CHANNELS];
	logic [TS_W-1:0] hold_ipk_ts_q [CHANNELS];

	logic [CH_IW-1:0] idx;
	logic in_range;
	logic unit_start;
	logic dec_done;
	logic mag_done;
	logic [MD_P_W-1:0] dec_quot;
	logic [MD_P_W-1:0] mag_quot;
	logic [MD_A_W-1:0] mag_a;
	logic [MD_D_W-1:0] mag_d;
	logic signed [16:0] mag_diff;
	logic [16:0] mag_abs;
	logic [16:0] dec_sat;
	logic [16:0] mag_sat;
	logic load;
	logic upd_pk_hold;
	logic upd_ipk_hold;
	logic signed [LVL_W-1:0] nxt_pk;
	logic signed [LVL_W-1:0] nxt_ipk;
	logic signed [LVL_W-1:0] nxt_mag;
	logic signed [17:0] mag_t;

	function automatic logic signed [15:0] peak_next(
		input logic v,
		input logic signed [15:0] disp,
		input logic signed [15:0] cur,
		input logic [16:0] dec
	);
		logic signed [17:0] t;
		logic signed [15:0] r;
		t = 18'(disp) - $signed({1'b0, dec});
		if (!v || cur >= disp) begin
			r = cur;
		end else if (t < 18'(cur)) begin
			r = cur;
		end else if (t > 18'sd0) begin
			r = '0;
		end else begin
			r = t[15:0];
		end
		return r;
	endfunction

	assign idx = CH_IW'(item_q.channel);
	assign in_range = int'(item_q.channel) < CHANNELS;

	assign update.ready = state_q == ST_IDLE;
	assign result.valid = res_v_q;
	assign result.data = res_q;

	assign unit_start = state_q == ST_START;
	assign mag_diff = 17'(item_q.magnitude_level) - 17'(disp_mag_q[idx]);
	assign mag_abs = mag_diff[16] ? 17'(-mag_diff) : 17'(mag_diff);
	assign mag_a = MD_A_W'(mag_abs[15:0]) * MD_A_W'(MAG_GAIN);
	assign mag_d = MD_D_W'((mag_time_q == '0) ? 24'd1 : mag_time_q) * MD_D_W'(MAG_DEN_GAIN);

	amb_muldiv #(.A_W(MD_A_W), .B_W(MD_B_W), .D_W(MD_D_W)) u_decay (
		.clk(clk), .arst_n(arst_n), .start(unit_start),
		.a(MD_A_W'(decay_rate_q)), .b(item_q.elapsed), .d(DECAY_DIV),
		.done(dec_done), .q(dec_quot)
	);

	amb_muldiv #(.A_W(MD_A_W), .B_W(MD_B_W), .D_W(MD_D_W)) u_mag (
		.clk(clk), .arst_n(arst_n), .start(unit_start),
		.a(mag_a), .b(item_q.elapsed), .d(mag_d),
		.done(mag_done), .q(mag_quot)
	);

	assign dec_sat = (dec_quot > MD_P_W'(16'hFFFF)) ? 17'h10000 : {1'b0, dec_quot[15:0]};
	assign mag_sat = (mag_quot > MD_P_W'(16'hFFFF)) ? 17'h10000 : {1'b0, mag_quot[15:0]};

	assign nxt_pk = peak_next(vld_q[idx], disp_pk_q[idx], item_q.peak_level, dec_sat);
	assign nxt_ipk = peak_next(vld_q[idx], disp_ipk_q[idx], item_q.input_peak_level, dec_sat);

	assign mag_t = mag_diff[16] ? 18'(disp_mag_q[idx]) - $signed({1'b0, mag_sat})
		: 18'(disp_mag_q[idx]) + $signed({1'b0, mag_sat});

	always_comb begin
		priority if (!vld_q[idx] || disp_mag_q[idx] == MINUS_INF) begin
			nxt_mag = item_q.magnitude_level;
		end else if (item_q.magnitude_level == MINUS_INF) begin
			nxt_mag = min_level_q;
		end else if (mag_t < 18'(min_level_q)) begin
			nxt_mag = min_level_q;
		end else if (mag_t > 18'sd0) begin
			nxt_mag = '0;
		end else begin
			nxt_mag = mag_t[15:0];
		end
	end

	assign upd_pk_hold = hold_pk_q[idx] == MINUS_INF || item_q.peak_level >= hold_pk_q[idx]
		|| (item_q.timestamp - hold_pk_ts_q[idx]) > peak_hold_q;
	assign upd_ipk_hold = hold_ipk_q[idx] == MINUS_INF
		|| item_q.input_peak_level >= hold_ipk_q[idx]
		|| (item_q.timestamp - hold_ipk_ts_q[idx]) > in_peak_hold_q;

	assign load = state_q == ST_FIN && (!res_v_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_v_q <= 1'b0;
		end else begin
			if (load) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (update.valid) state_q <= ST_START;
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: if (dec_done) state_q <= ST_FIN;
				ST_FIN: if (load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (update.valid && update.ready) begin
			item_q <= update.data;
		end
		if (load) begin
			res_q.out_channel <= item_q.channel;
			res_q.shown_peak <= in_range ? nxt_pk : MINUS_INF;
			res_q.shown_input_peak <= in_range ? nxt_ipk : MINUS_INF;
			res_q.shown_peak_hold <= !in_range ? MINUS_INF
				: (upd_pk_hold ? item_q.peak_level : hold_pk_q[idx]);
			res_q.shown_input_peak_hold <= !in_range ? MINUS_INF
				: (upd_ipk_hold ? item_q.input_peak_level : hold_ipk_q[idx]);
			res_q.shown_magnitude <= in_range ? nxt_mag : MINUS_INF;
		end
		if (load && in_range) begin
			disp_pk_q[idx] <= nxt_pk;
			disp_ipk_q[idx] <= nxt_ipk;
			disp_mag_q[idx] <= nxt_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				vld_q[i] <= 1'b0;
				hold_pk_q[i] <= MINUS_INF;
				hold_ipk_q[i] <= MINUS_INF;
				hold_pk_ts_q[i] <= '0;
				hold_ipk_ts_q[i] <= '0;
			end
		end else if (load && in_range) begin
			vld_q[idx] <= 1'b1;
			if (upd_pk_hold) begin
				hold_pk_q[idx] <= item_q.peak_level;
				hold_pk_ts_q[idx] <= item_q.timestamp;
			end
			if (upd_ipk_hold) begin
				hold_ipk_q[idx] <= item_q.input_peak_level;
				hold_ipk_ts_q[idx] <= item_q.timestamp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_rate_q <= RST_PEAK_DECAY;
			mag_time_q <= RST_MAG_TIME;
			peak_hold_q <= RST_PEAK_HOLD;
			in_peak_hold_q <= RST_IN_PEAK_HOLD;
			min_level_q <= RST_MIN_LEVEL;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				REG_PEAK_DECAY: decay_rate_q <= cfg_wdata[15:0];
				REG_MAG_TIME: mag_time_q <= cfg_wdata[23:0];
				REG_PEAK_HOLD: peak_hold_q <= cfg_wdata;
				REG_IN_PEAK_HOLD: in_peak_hold_q <= cfg_wdata;
				REG_MIN_LEVEL: min_level_q <= cfg_wdata[15:0];
				default: decay_rate_q <= decay_rate_q;
			endcase
		end
	end

	a_units_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		dec_done == mag_done)
		else $error("multiply-divide units out of step");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> result.valid && state_q == ST_IDLE)
		else $error("loaded result not presented");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT || state_q == ST_FIN) |-> !update.ready)
		else $error("item taken while busy");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && int'(result.data.out_channel) >= CHANNELS)
		|-> result.data.shown_peak == MINUS_INF && result.data.shown_magnitude == MINUS_INF)
		else $error("unknown channel gave a level");
endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the meter ballistics block: directed and random updates.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import amb_pkg::*;

	typedef struct {
		in_item_t upd_in;
		bit known;
		out_item_t known_out;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	amb_stream_if #(.T(in_item_t)) upd();
	amb_stream_if #(.T(out_item_t)) res();

	audio_meter_ballistics dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.update(upd.sink),
		.result(res.source)
	);

	// register mirror
	int unsigned decay_rate;
	int unsigned integ_time;
	int unsigned pk_hold_dur;
	int unsigned ipk_hold_dur;
	int min_lvl;

	// per-channel meter state
	int pk_disp[CHANNELS_DEF];
	int ipk_disp[CHANNELS_DEF];
	int mag_disp[CHANNELS_DEF];
	int pk_hold[CHANNELS_DEF];
	int ipk_hold[CHANNELS_DEF];
	logic [31:0] pk_hold_ts[CHANNELS_DEF];
	logic [31:0] ipk_hold_ts[CHANNELS_DEF];
	logic [2:0] seen[CHANNELS_DEF];
	logic [31:0] ts_now[CHANNELS_DEF];

	out_item_t pending_results[$];
	int errors;
	int items_sent;
	int results_seen;
	bit idle_on;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

	function automatic int decay_level(bit ok, int disp, int cur, int unsigned el);
		longint t;
		if (!ok || cur >= disp)
			return cur;
		t = longint'(disp) - longint'((longint'(decay_rate) * el) / 1000000);
		if (t < cur)
			t = cur;
		else if (t > 0)
			t = 0;
		if (t < -32768)
			t = -32768;
		return int'(t);
	endfunction

	function automatic int integrate_level(bit ok, int disp, int cur, int unsigned el);
		longint diff;
		longint amt;
		longint den;
		longint t;
		if (!ok || disp == -32768)
			return cur;
		if (cur == -32768)
			return min_lvl;
		diff = longint'(cur) - longint'(disp);
		den = longint'(integ_time == 0 ? 1 : integ_time) * 100;
		amt = ((diff < 0 ? -diff : diff) * el * 99) / den;
		t = disp + (diff < 0 ? -amt : amt);
		if (t < min_lvl)
			t = min_lvl;
		else if (t > 0)
			t = 0;
		return int'(t);
	endfunction

	function automatic out_item_t advance_meter(in_item_t it);
		out_item_t o;
		int ch;
		int pk;
		int ipk;
		int mg;
		int unsigned el;
		logic [31:0] age;
		ch = it.channel;
		pk = it.peak_level;
		ipk = it.input_peak_level;
		mg = it.magnitude_level;
		el = it.elapsed;
		pk_disp[ch] = decay_level(seen[ch][0], pk_disp[ch], pk, el);
		ipk_disp[ch] = decay_level(seen[ch][1], ipk_disp[ch], ipk, el);
		age = it.timestamp - pk_hold_ts[ch];
		if (pk_hold[ch] == -32768 || pk >= pk_hold[ch] || age > pk_hold_dur) begin
			pk_hold[ch] = pk;
			pk_hold_ts[ch] = it.timestamp;
		end
		age = it.timestamp - ipk_hold_ts[ch];
		if (ipk_hold[ch] == -32768 || ipk >= ipk_hold[ch] || age > ipk_hold_dur) begin
			ipk_hold[ch] = ipk;
			ipk_hold_ts[ch] = it.timestamp;
		end
		mag_disp[ch] = integrate_level(seen[ch][2], mag_disp[ch], mg, el);
		seen[ch] = 3'b111;
		o.out_channel = it.channel;
		o.shown_peak = 16'(pk_disp[ch]);
		o.shown_input_peak = 16'(ipk_disp[ch]);
		o.shown_peak_hold = 16'(pk_hold[ch]);
		o.shown_input_peak_hold = 16'(ipk_hold[ch]);
		o.shown_magnitude = 16'(mag_disp[ch]);
		return o;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_PEAK_DECAY: decay_rate = val[15:0];
			REG_MAG_TIME: integ_time = val[23:0];
			REG_PEAK_HOLD: pk_hold_dur = val;
			REG_IN_PEAK_HOLD: ipk_hold_dur = val;
			REG_MIN_LEVEL: min_lvl = $signed(val[15:0]);
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send_update(in_item_t it, bit known, out_item_t known_out);
		out_item_t pred;
		if (idle_on && $urandom_range(99) < 17) begin
			upd.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		upd.valid <= 1'b1;
		upd.data <= it;
		pred = advance_meter(it);
		pending_results.push_back(known ? known_out : pred);
		items_sent++;
		@(posedge clk);
		while (!upd.ready)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_level();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 16'h8000;
		if (r < 12)
			return 16'($urandom);
		if (r < 15)
			return 16'h7FFF;
		return 16'($signed(-$urandom_range(0, 16000)));
	endfunction

	function automatic in_item_t make_update();
		in_item_t it;
		int ch;
		ch = $urandom_range(CHANNELS_DEF - 1);
		it.channel = 3'(ch);
		if ($urandom_range(99) < 85) begin
			it.elapsed = ($urandom_range(99) < 90) ? 24'($urandom_range(0, 60000))
				: 24'($urandom);
			ts_now[ch] = ts_now[ch] + it.elapsed + $urandom_range(0, 3000000);
			it.timestamp = ts_now[ch];
			it.peak_level = pick_level();
			it.input_peak_level = pick_level();
			it.magnitude_level = pick_level();
		end else begin
			it.timestamp = $urandom;
			it.elapsed = 24'($urandom);
			it.peak_level = 16'($urandom);
			it.input_peak_level = 16'($urandom);
			it.magnitude_level = 16'($urandom);
		end
		return it;
	endfunction

	function automatic bit check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// result side: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			res.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (results_seen == 300 && res.valid && res.ready) begin
			res.ready <= 1'b0;
			hold_left <= 600;
		end else begin
			res.ready <= idle_on ? ($urandom_range(99) >= 17) : 1'b1;
		end
	end

	always @(posedge clk) begin
		out_item_t exp_o;
		int bad;
		if (arst_n && res.valid && res.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with no update pending");
				errors++;
			end else begin
				exp_o = pending_results.pop_front();
				bad = 0;
				bad += check_field("out_channel", 16'(exp_o.out_channel),
					16'(res.data.out_channel));
				bad += check_field("shown_peak", exp_o.shown_peak, res.data.shown_peak);
				bad += check_field("shown_input_peak", exp_o.shown_input_peak,
					res.data.shown_input_peak);
				bad += check_field("shown_peak_hold", exp_o.shown_peak_hold,
					res.data.shown_peak_hold);
				bad += check_field("shown_input_peak_hold", exp_o.shown_input_peak_hold,
					res.data.shown_input_peak_hold);
				bad += check_field("shown_magnitude", exp_o.shown_magnitude,
					res.data.shown_magnitude);
				if (bad != 0)
					errors++;
			end
		end
	end

	function automatic dir_row_t row(int ch, logic [31:0] ts, logic [23:0] el, logic [15:0] pk,
			logic [15:0] ipk, logic [15:0] mg, bit known);
		dir_row_t r;
		r.upd_in = '{channel: 3'(ch), timestamp: ts, elapsed: el, peak_level: pk,
			input_peak_level: ipk, magnitude_level: mg};
		r.known = known;
		r.known_out = '{out_channel: 3'(ch), shown_peak: pk, shown_input_peak: ipk,
			shown_peak_hold: pk, shown_input_peak_hold: ipk, shown_magnitude: mg};
		return r;
	endfunction

	initial begin
		dir_row_t dir_rows[$];
		int n;
		out_item_t unused;
		cfg_wr_en <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		upd.valid <= 1'b0;
		upd.data <= '0;
		arst_n <= 1'b0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		idle_on = 1'b1;
		decay_rate = RST_PEAK_DECAY;
		integ_time = RST_MAG_TIME;
		pk_hold_dur = RST_PEAK_HOLD;
		ipk_hold_dur = RST_IN_PEAK_HOLD;
		min_lvl = RST_MIN_LEVEL;
		for (int c = 0; c < CHANNELS_DEF; c++) begin
			pk_disp[c] = 0;
			ipk_disp[c] = 0;
			mag_disp[c] = 0;
			pk_hold[c] = -32768;
			ipk_hold[c] = -32768;
			pk_hold_ts[c] = '0;
			ipk_hold_ts[c] = '0;
			seen[c] = '0;
			ts_now[c] = $urandom;
		end
		unused = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// first touch of a channel passes levels straight through
		dir_rows.push_back(row(0, 32'h0, 24'h0, 16'h7FFF, 16'h8000, 16'h0000, 1));
		dir_rows.push_back(row(1, 32'hFFFFFFFF, 24'hFFFFFF, 16'h8000, 16'h8000, 16'h8000, 1));
		dir_rows.push_back(row(2, 32'd1000, 24'd1000, 16'hC400, 16'hF000, 16'hE000, 1));
		dir_rows.push_back(row(7, 32'd5, 24'd20000, 16'h0000, 16'h7FFF, 16'h7FFF, 1));
		// decay, clamp to current, clamp to zero, minus infinity handling
		dir_rows.push_back(row(0, 32'd20000, 24'd20000, 16'hF000, 16'hF000, 16'hF000, 0));
		dir_rows.push_back(row(0, 32'd40000, 24'hFFFFFF, 16'h8000, 16'h8000, 16'h8000, 0));
		dir_rows.push_back(row(0, 32'd60000, 24'd50000, 16'hE000, 16'hE000, 16'hE000, 0));
		dir_rows.push_back(row(2, 32'd30000000, 24'd300000, 16'hD000, 16'hD000, 16'h0100, 0));
		dir_rows.push_back(row(2, 32'd30020000, 24'd0, 16'hD000, 16'hD000, 16'hC000, 0));
		dir_rows.push_back(row(1, 32'd3, 24'd100, 16'hF000, 16'hF000, 16'hF000, 0));
		dir_rows.push_back(row(1, 32'd4, 24'd100, 16'hE000, 16'hE000, 16'h8000, 0));
		dir_rows.push_back(row(7, 32'd3000000, 24'd16000, 16'hF800, 16'hF800, 16'hF800, 0));
		dir_rows.push_back(row(7, 32'd30000000, 24'd16000, 16'hF700, 16'hF700, 16'h0000, 0));
		dir_rows.push_back(row(3, 32'hFFFFFFF0, 24'd10, 16'hFF00, 16'hFF00, 16'hFF00, 0));
		dir_rows.push_back(row(3, 32'h00000010, 24'd10, 16'hFE00, 16'hFE00, 16'hFE00, 0));
		dir_rows.push_back(row(4, 32'hAAAAAAAA, 24'h555555, 16'h5555, 16'hAAAA, 16'h5555, 1));
		dir_rows.push_back(row(4, 32'h55555555, 24'hAAAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 0));
		foreach (dir_rows[i])
			send_update(dir_rows[i].upd_in, dir_rows[i].known, dir_rows[i].known_out);

		for (int ph = 0; ph < 5; ph++) begin
			upd.valid <= 1'b0;
			drain();
			case (ph)
				1: begin
					write_reg(REG_PEAK_DECAY, 32'hFFFF);
					write_reg(REG_MAG_TIME, 32'd1);
					write_reg(REG_PEAK_HOLD, 32'd0);
					write_reg(REG_IN_PEAK_HOLD, 32'd0);
					write_reg(REG_MIN_LEVEL, 32'hFFFF8000);
				end
				2: begin
					write_reg(REG_PEAK_DECAY, 32'd0);
					write_reg(REG_MAG_TIME, 32'hFFFFFF);
					write_reg(REG_PEAK_HOLD, 32'hFFFFFFFF);
					write_reg(REG_IN_PEAK_HOLD, 32'hFFFFFFFF);
					write_reg(REG_MIN_LEVEL, 32'd0);
				end
				3: begin
					write_reg(REG_PEAK_DECAY, $urandom_range(100, 20000));
					write_reg(REG_MAG_TIME, 32'd0);
					write_reg(REG_PEAK_HOLD, $urandom_range(0, 5000000));
					write_reg(REG_IN_PEAK_HOLD, $urandom_range(0, 2000000));
					write_reg(REG_MIN_LEVEL, 32'($signed(-$urandom_range(1, 32767))));
				end
				4: begin
					write_reg(REG_PEAK_DECAY, 32'(RST_PEAK_DECAY));
					write_reg(REG_MAG_TIME, 32'(RST_MAG_TIME));
					write_reg(REG_PEAK_HOLD, RST_PEAK_HOLD);
					write_reg(REG_IN_PEAK_HOLD, RST_IN_PEAK_HOLD);
					write_reg(REG_MIN_LEVEL, 32'($signed(RST_MIN_LEVEL)));
				end
				default: ;
			endcase
			n = (ph == 0) ? 450 : 270;
			for (int k = 0; k < n; k++) begin
				idle_on = !(ph == 0 && k >= 330);
				send_update(make_update(), 1'b0, unused);
			end
			idle_on = 1'b1;
		end
		upd.valid <= 1'b0;
		drain();

		$display("Sent %0d meter updates over five register settings, %0d results checked.",
			items_sent, results_seen);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
